FILE: rtl/gaps_pkg.sv
// gaps_pkg: shared constants and types for the above-plus-left grid sum block
// and its port checker
// depends on nothing
package gaps_pkg;

  localparam int DATA_W       = 32;  // cell_value and result_value
  localparam int ROW_LEN_W    = 11;  // row_length register
  localparam int CFG_AW       = 3;   // byte address, one 32-bit register
  localparam int CFG_DW       = 32;
  localparam int CFG_IDX_LSB  = 2;   // word index starts above the byte offset

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [ROW_LEN_W-1:0] row_len_t;
  typedef logic [CFG_AW-1:0]    cfg_addr_t;
  typedef logic [CFG_DW-1:0]    cfg_data_t;

  // register indexes
  typedef enum logic [CFG_AW-CFG_IDX_LSB-1:0] {
    REG_ROW_LENGTH = 1'b0
  } reg_idx_t;

  localparam row_len_t ROW_LEN_RESET = row_len_t'(1024);

endpackage

FILE: rtl/grid_above_plus_left_sum.sv
// grid_above_plus_left_sum: streaming above-plus-left recurrence over a matrix
// uses gaps_pkg; holds the line buffer memory, the input stage and the result register
//
// The block takes a matrix as a row-major stream of 32-bit cells, one per
// transaction, and returns one result transaction per cell, in order. Cells of
// the first row and of column 0 pass through; every other cell becomes the
// new value above plus the new value to its left, wrapping modulo 2^32, and
// its own input value is dropped. in_tlast marks the last cell of a matrix;
// it comes back on out_tlast of that cell's result and sends the position
// back to row 0, column 0. Throughput is one cell per clock while out_tready
// stays high: the line buffer has one write port and one registered read
// port, the read address (the cell's own column) is known when a cell is
// accepted, and the add sits between the input stage and the result register.
// A cell passes the input stage and then the result register before its result
// is valid. The row length lives in register 0 (byte address 0) of the APB
// port; 0 or 1 acts as 1, a value above MAX_COLUMNS acts as MAX_COLUMNS.
// Change it only while no cell is in flight. After a raise of the length
// inside a matrix, cells that read never-written line buffer entries give
// undefined results. The line buffer has no reset and needs no clearing pass.
module grid_above_plus_left_sum #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gaps_pkg::data_t   in_tdata,    // [31:0] cell_value
  input  logic              in_tlast,    // end_of_matrix
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output gaps_pkg::data_t   out_tdata,   // [31:0] result_value
  output logic              out_tlast,   // matrix_done
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  gaps_pkg::cfg_addr_t cfg_paddr,
  input  gaps_pkg::cfg_data_t cfg_pwdata,
  output gaps_pkg::cfg_data_t cfg_prdata,
  output logic              cfg_pready
);
  import gaps_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int MAXL_W = $clog2(MAX_COLUMNS + 1);
  localparam int LEN_W = (MAXL_W > ROW_LEN_W) ? MAXL_W : ROW_LEN_W;

  // configuration register
  row_len_t row_length_r;
  logic     cfg_wr;
  logic     cfg_hit;

  // position state, advanced at input transaction
  logic [COL_W-1:0] col_r, col_nxt;
  logic             first_row_r, first_row_nxt;

  // input stage
  logic             s1_valid_r;
  data_t            s1_cell_r;
  logic             s1_last_r;
  logic             s1_pass_r;
  logic [COL_W-1:0] s1_col_r;
  data_t            s1_above_r;

  // running left value and result register
  data_t left_r;
  logic  out_valid_r;
  data_t out_data_r;
  logic  out_last_r;

  // line buffer
  data_t line_mem [MAX_COLUMNS];

  logic             in_fire;
  logic             s1_fire;
  logic [LEN_W-1:0] len_raw, len_eff, last_col, col_ext;
  logic [COL_W-1:0] col_use;
  logic             row_end;
  data_t            value;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:CFG_IDX_LSB] == REG_ROW_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? cfg_data_t'(row_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
    end else if (cfg_wr) begin
      row_length_r <= cfg_pwdata[ROW_LEN_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  // input stage moves on whenever the result register is free or being taken
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- position tracking ----------------
  always_comb begin
    len_raw = LEN_W'(row_length_r);
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_COLUMNS)) begin
      len_eff = LEN_W'(MAX_COLUMNS);
    end else begin
      len_eff = len_raw;
    end
    last_col = len_eff - LEN_W'(1);
    col_ext  = LEN_W'(col_r);
    // a column at or past the last one counts as the last one
    if (col_ext >= last_col) begin
      col_use = last_col[COL_W-1:0];
      row_end = 1'b1;
    end else begin
      col_use = col_r;
      row_end = 1'b0;
    end

    if (in_tlast) begin
      col_nxt       = '0;
      first_row_nxt = 1'b1;
    end else if (row_end) begin
      col_nxt       = '0;
      first_row_nxt = 1'b0;
    end else begin
      col_nxt       = col_use + COL_W'(1);
      first_row_nxt = first_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else if (in_fire) begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  // ---------------- input stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r <= in_tdata;
      s1_last_r <= in_tlast;
      s1_pass_r <= first_row_r || (col_use == '0);
      s1_col_r  <= col_use;
    end
  end

  // line buffer: the entry above was written a full row earlier, before this read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_above_r <= line_mem[col_use];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= value;
    end
  end

  // ---------------- sum and result register ----------------
  assign value = s1_pass_r ? s1_cell_r : (s1_above_r + left_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_fire) begin
      left_r <= s1_last_r ? '0 : value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= value;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/gaps_checker.sv
// gaps_checker: port-level checks for grid_above_plus_left_sum
// uses gaps_pkg; bound to the top level at the end of this file
module gaps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input gaps_pkg::data_t     in_tdata,
  input logic                in_tlast,
  input logic                out_tvalid,
  input logic                out_tready,
  input gaps_pkg::data_t     out_tdata,
  input logic                out_tlast
);
  import gaps_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] inflight_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // cells accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // with the result register empty the block always takes a cell
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result register empty");

  // at most two cells in flight: input stage and result register
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd2)
    else $error("more cells in flight than pipeline stages");

  // no result without a cell behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != 3'd0)
    else $error("result shown with no cell in flight");

endmodule

bind grid_above_plus_left_sum gaps_checker u_gaps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
